/* sv/indexed_max_heap_top_defines.svh */
// Assertion macros for the indexed max-heap checker.
`ifndef INDEXED_MAX_HEAP_TOP_DEFINES_SVH
`define INDEXED_MAX_HEAP_TOP_DEFINES_SVH
// property that holds under reset-disable
`define IMH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property that holds at every edge, reset included
`define IMH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* sv/imh_pkg.sv */
// Package: types and constants for the indexed max-heap.
package imh_pkg;
    localparam int DEF_CAPACITY = 256;
    localparam int KEY_W   = 8;
    localparam int PRIO_W  = 32;
    localparam int ENTRY_W = KEY_W + PRIO_W;
    localparam int NKEYS   = 256;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_ABSENT = 3'd3;
    localparam logic [2:0] ST_DUP    = 3'd4;

    localparam logic [PRIO_W-1:0] TOP_PRIO = 32'hFFFF_FFFF;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_INS_WR,
        S_UP_RD,
        S_UP_WAIT,
        S_UP_CMP,
        S_UP_WR,
        S_RM_SLOT,
        S_RM_SLOTW,
        S_RM_LAST,
        S_RM_LASTW,
        S_RM_ROOT,
        S_DN_RD,
        S_DN_WAIT,
        S_DN_CMPL,
        S_DN_CMPR,
        S_DN_WR,
        S_Q_RD,
        S_Q_WAIT,
        S_Q_CMP,
        S_TOP_RD,
        S_TOP_WAIT,
        S_OUT
    } state_t;
endpackage

/* sv/indexed_max_heap_top.sv */
// Top level of the indexed max-heap: sequencer, heap and slot memories.
//  channel | dir | signals                      | content
//  s_axis  | in  | tvalid tready tdata tuser    | tdata: key, priority; tuser: kind
//  m_axis  | out | tvalid tready tdata          | status,count,top_key,top_prio,min_key,min_prio
// An insert sifts the new entry up level by level, a remove sifts a forced entry
// up and the last entry down, and a min query scans every leaf; the single heap
// read port and the shared comparator make these steps run one at a time.
// Reset clears presence bits and count at once; memories are undefined until written.
// s_axis_tready is low from acceptance until the result beat is taken.
module indexed_max_heap_top #(
    parameter int CAPACITY = imh_pkg::DEF_CAPACITY
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // [7:0] item_key, [39:8] item_priority
    input  logic [1:0]   s_axis_tuser,   // [1:0] kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata    // status[2:0] count[11:3] top_key[19:12]
                                         // top_priority[51:20] min_key[59:52]
                                         // min_priority[91:60], zero above
);
    import imh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;
    logic [1:0]          kind_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [PRIO_W-1:0]   prio_reg;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       pos_reg, pos_next;     // current slot
    logic [CW-1:0]       oth_reg, oth_next;     // parent / child / scan slot
    logic [CW-1:0]       big_reg, big_next;
    logic [ENTRY_W-1:0]  cur_reg, cur_next;     // entry being moved
    logic [ENTRY_W-1:0]  bige_reg, bige_next;
    logic [ENTRY_W-1:0]  min_reg, min_next;
    logic [ENTRY_W-1:0]  top_reg, top_next;
    logic [2:0]          status_reg, status_next;
    logic                forced_reg, forced_next;
    logic                wr_phase_reg, wr_phase_next;
    logic [NKEYS-1:0]    present_reg;
    logic                pres_set, pres_clr;

    // heap memory
    logic               h_we;
    logic [AW-1:0]      h_waddr, h_raddr;
    logic [ENTRY_W-1:0] h_wdata, h_rdata;
    // slot memory
    logic               k_we;
    logic [KEY_W-1:0]   k_waddr;
    logic [AW-1:0]      k_wdata, k_rdata;

    imh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );
    imh_ram #(.WIDTH(AW), .DEPTH(NKEYS)) u_slot (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(key_reg), .rdata(k_rdata)
    );

    logic [ENTRY_W-1:0] cmp_a, cmp_b;
    logic               cmp_gt;
    imh_cmp u_cmp (.a(cmp_a), .b(cmp_b), .a_gt_b(cmp_gt));

    logic [CW:0] lchild;
    assign lchild = {pos_reg, 1'b1};
    logic [CW-1:0] parent;
    assign parent = (pos_reg - CW'(1)) >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            present_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (pres_set)
            begin
                present_reg[key_reg] <= 1'b1;
            end
            if (pres_clr)
            begin
                present_reg[key_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            kind_reg <= s_axis_tuser;
            key_reg  <= s_axis_tdata[7:0];
            prio_reg <= s_axis_tdata[39:8];
        end
        pos_reg      <= pos_next;
        oth_reg      <= oth_next;
        big_reg      <= big_next;
        cur_reg      <= cur_next;
        bige_reg     <= bige_next;
        min_reg      <= min_next;
        top_reg      <= top_next;
        status_reg   <= status_next;
        forced_reg   <= forced_next;
        wr_phase_reg <= wr_phase_next;
    end

    // next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        oth_next      = oth_reg;
        big_next      = big_reg;
        cur_next      = cur_reg;
        bige_next     = bige_reg;
        min_next      = min_reg;
        top_next      = top_reg;
        status_next   = status_reg;
        forced_next   = forced_reg;
        wr_phase_next = wr_phase_reg;
        pres_set      = 1'b0;
        pres_clr      = 1'b0;
        h_we    = 1'b0;
        h_waddr = pos_reg[AW-1:0];
        h_wdata = cur_reg;
        h_raddr = oth_reg[AW-1:0];
        k_we    = 1'b0;
        k_waddr = cur_reg[KEY_W-1:0];
        k_wdata = pos_reg[AW-1:0];
        cmp_a   = h_rdata;
        cmp_b   = cur_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                status_next = ST_DONE;
                min_next    = '0;
                state_next  = S_TOP_RD;
                if (kind_reg == KIND_INSERT)
                begin
                    if (present_reg[key_reg])
                    begin
                        status_next = ST_DUP;
                    end
                    else if (cnt_reg == CW'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        pos_next    = cnt_reg;
                        cur_next    = {prio_reg, key_reg};
                        cnt_next    = cnt_reg + CW'(1);
                        pres_set    = 1'b1;
                        forced_next = 1'b0;
                        state_next  = S_INS_WR;
                    end
                end
                else if (kind_reg == KIND_REMOVE)
                begin
                    if (!present_reg[key_reg] || cnt_reg == '0)
                    begin
                        status_next = ST_ABSENT;
                    end
                    else
                    begin
                        pres_clr    = 1'b1;
                        forced_next = 1'b1;
                        state_next  = S_RM_SLOT;
                    end
                end
                else if (kind_reg == KIND_QUERY)
                begin
                    if (cnt_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        oth_next   = cnt_reg >> 1;
                        min_next   = '1;
                        state_next = S_Q_RD;
                    end
                end
            end
            S_INS_WR:
            begin
                h_we       = 1'b1;
                k_we       = 1'b1;
                state_next = S_UP_RD;
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = (kind_reg == KIND_REMOVE) ? S_RM_LAST : S_TOP_RD;
                end
                else
                begin
                    oth_next   = parent;
                    state_next = S_UP_WAIT;
                end
            end
            S_UP_WAIT:
            begin
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                cmp_a = cur_reg;
                cmp_b = h_rdata;
                if (forced_reg || cmp_gt)
                begin
                    bige_next     = h_rdata;
                    wr_phase_next = 1'b0;
                    state_next    = S_UP_WR;
                end
                else
                begin
                    state_next = (kind_reg == KIND_REMOVE) ? S_RM_LAST : S_TOP_RD;
                end
            end
            S_UP_WR:
            begin
                // first phase writes the parent entry down to pos, second the moved entry up to parent
                if (!wr_phase_reg)
                begin
                    h_we          = 1'b1;
                    h_wdata       = bige_reg;
                    k_we          = 1'b1;
                    k_waddr       = bige_reg[KEY_W-1:0];
                    wr_phase_next = 1'b1;
                end
                else
                begin
                    h_we       = 1'b1;
                    h_waddr    = oth_reg[AW-1:0];
                    k_we       = 1'b1;
                    k_wdata    = oth_reg[AW-1:0];
                    pos_next   = oth_reg;
                    state_next = S_UP_RD;
                end
            end
            S_RM_SLOT:
            begin
                state_next = S_RM_SLOTW;
            end
            S_RM_SLOTW:
            begin
                pos_next = ({1'b0, k_rdata} >= cnt_reg) ? '0 : CW'(k_rdata);
                cur_next = {TOP_PRIO, key_reg};
                state_next = S_INS_WR;
            end
            S_RM_LAST:
            begin
                if (cnt_reg == CW'(1))
                begin
                    cnt_next   = '0;
                    state_next = S_TOP_RD;
                end
                else
                begin
                    oth_next   = cnt_reg - CW'(1);
                    state_next = S_RM_LASTW;
                end
            end
            S_RM_LASTW:
            begin
                state_next = S_RM_ROOT;
            end
            S_RM_ROOT:
            begin
                cur_next   = h_rdata;
                pos_next   = '0;
                h_we       = 1'b1;
                h_waddr    = '0;
                h_wdata    = h_rdata;
                k_we       = 1'b1;
                k_waddr    = h_rdata[KEY_W-1:0];
                k_wdata    = '0;
                cnt_next   = cnt_reg - CW'(1);
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                big_next  = pos_reg;
                bige_next = cur_reg;
                if (lchild < {1'b0, cnt_reg})
                begin
                    oth_next   = lchild[CW-1:0];
                    state_next = S_DN_WAIT;
                end
                else
                begin
                    state_next = S_TOP_RD;
                end
            end
            S_DN_WAIT:
            begin
                state_next = S_DN_CMPL;
            end
            S_DN_CMPL:
            begin
                cmp_b = bige_reg;
                if (cmp_gt)
                begin
                    big_next  = oth_reg;
                    bige_next = h_rdata;
                end
                wr_phase_next = 1'b0;
                if ((oth_reg + CW'(1)) < cnt_reg && oth_reg != '1)
                begin
                    oth_next   = oth_reg + CW'(1);
                    state_next = S_DN_CMPR;
                end
                else
                begin
                    state_next = S_DN_WR;
                end
            end
            S_DN_CMPR:
            begin
                // right child is compared after a wait phase in this state, once its read data arrives
                if (wr_phase_reg)
                begin
                    cmp_b = bige_reg;
                    if (cmp_gt)
                    begin
                        big_next  = oth_reg;
                        bige_next = h_rdata;
                    end
                    wr_phase_next = 1'b0;
                    state_next    = S_DN_WR;
                end
                else
                begin
                    wr_phase_next = 1'b1;
                end
            end
            S_DN_WR:
            begin
                if (big_reg == pos_reg)
                begin
                    state_next = S_TOP_RD;
                end
                else if (!wr_phase_reg)
                begin
                    h_we          = 1'b1;
                    h_wdata       = bige_reg;
                    k_we          = 1'b1;
                    k_waddr       = bige_reg[KEY_W-1:0];
                    wr_phase_next = 1'b1;
                end
                else
                begin
                    h_we       = 1'b1;
                    h_waddr    = big_reg[AW-1:0];
                    k_we       = 1'b1;
                    k_wdata    = big_reg[AW-1:0];
                    pos_next   = big_reg;
                    state_next = S_DN_RD;
                end
            end
            S_Q_RD:
            begin
                state_next = S_Q_WAIT;
            end
            S_Q_WAIT:
            begin
                state_next = S_Q_CMP;
            end
            S_Q_CMP:
            begin
                cmp_b = min_reg;
                if (!cmp_gt)
                begin
                    min_next = h_rdata;
                end
                if ((oth_reg + CW'(1)) < cnt_reg && oth_reg != '1)
                begin
                    oth_next   = oth_reg + CW'(1);
                    state_next = S_Q_RD;
                end
                else
                begin
                    state_next = S_TOP_RD;
                end
            end
            S_TOP_RD:
            begin
                oth_next   = '0;
                state_next = S_TOP_WAIT;
            end
            S_TOP_WAIT:
            begin
                h_raddr    = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                h_raddr = '0;
                top_next = (cnt_reg == '0) ? '0 : h_rdata;
                if (m_axis_tvalid && m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid is registered from S_OUT, so it rises together with the registered top entry
    logic out_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_OUT && !out_valid_reg)
        begin
            out_valid_reg <= 1'b1;
        end
    end

    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = {4'd0, min_reg[ENTRY_W-1:KEY_W], min_reg[KEY_W-1:0],
                         top_reg[ENTRY_W-1:KEY_W], top_reg[KEY_W-1:0],
                         9'(cnt_reg), status_reg};
    end
endmodule

/* sv/imh_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/imh_cmp.sv */
// Shared entry comparator: the one compare unit used by every sift and scan step.
module imh_cmp
    import imh_pkg::*;
(
    input  logic [ENTRY_W-1:0] a,
    input  logic [ENTRY_W-1:0] b,
    output logic               a_gt_b
);
    assign a_gt_b = (a > b);
endmodule

/* sv/imh_checker.sv */
// Port-level checker for the indexed max-heap, bound to the top level.
`include "indexed_max_heap_top_defines.svh"
module imh_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata
);
    logic       stall;
    logic       in_beat;
    logic [8:0] out_count;

    assign stall     = m_axis_tvalid && !m_axis_tready;
    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign out_count = m_axis_tdata[11:3];

    // no new input while a result beat is pending
    `IMH_ASSERT(a_busy, clk, rst_n, m_axis_tvalid |-> !s_axis_tready, "ready with result pending")
    // result holds while stalled
    `IMH_ASSERT(a_hold, clk, rst_n, stall |=> $stable(m_axis_tdata), "result changed under stall")
    // count never exceeds 256
    `IMH_ASSERT(a_cnt, clk, rst_n, m_axis_tvalid |-> out_count <= 9'd256, "count out of range")
    // accepted input blocks further input next cycle
    `IMH_ASSERT(a_acc, clk, rst_n, in_beat |=> !s_axis_tready, "ready right after accept")
    // no result beat offered during reset
    `IMH_ASSERT_ALWAYS(a_rst, clk, !rst_n |-> !m_axis_tvalid, "result valid in reset")
endmodule

bind indexed_max_heap_top imh_checker u_imh_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

/* verif/indexed_max_heap_top_tb.sv */
// Self-checking testbench for the indexed max-heap: directed and random heap operations.
module indexed_max_heap_top_tb;
    import imh_pkg::*;

    localparam int CAP       = 256;
    localparam int N_RANDOM  = 380;
    localparam int MAX_CYC   = 2000000;

    // first member in the highest bits: status ends up at [2:0]
    typedef struct packed {
        logic [31:0] min_prio;
        logic [7:0]  min_key;
        logic [31:0] top_prio;
        logic [7:0]  top_key;
        logic [8:0]  count;
        logic [2:0]  status;
    } heap_result_t;

    // Behavioral heap: computes the expected result of each operation.
    class heap_scoreboard;
        logic [39:0]  slots[CAP];
        int           slot_of[256];
        bit           present[256];
        int           n_held;
        heap_result_t pending[$];
        int           n_errors;
        int           n_checked;
        int           n_ops[4];

        function new();
            n_held = 0;
            n_errors = 0;
            n_checked = 0;
            foreach (present[i]) present[i] = 0;
            foreach (n_ops[i]) n_ops[i] = 0;
        endfunction

        function void put(int s, logic [39:0] e);
            slots[s] = e;
            slot_of[e[7:0]] = s;
        endfunction

        function void swap_slots(int a, int b);
            logic [39:0] ea;
            ea = slots[a];
            put(a, slots[b]);
            put(b, ea);
        endfunction

        function void bubble_up(int s, bit forced);
            int p;
            while (s != 0) begin
                p = (s - 1) / 2;
                if (!forced && !(slots[p] < slots[s]))
                    break;
                swap_slots(p, s);
                s = p;
            end
        endfunction

        function void bubble_down(int s);
            int l;
            int r;
            int big;
            forever begin
                l = 2 * s + 1;
                r = l + 1;
                big = s;
                if (l < n_held && slots[l] > slots[big]) big = l;
                if (r < n_held && slots[r] > slots[big]) big = r;
                if (big == s)
                    break;
                swap_slots(s, big);
                s = big;
            end
        endfunction

        function void note_item(logic [1:0] kind, logic [7:0] key, logic [31:0] prio);
            heap_result_t res;
            int s;
            logic [39:0] mn;
            res = '0;
            mn = '0;
            n_ops[kind]++;
            if (kind == KIND_INSERT) begin
                if (present[key]) res.status = ST_DUP;
                else if (n_held >= CAP) res.status = ST_FULL;
                else begin
                    s = n_held;
                    n_held++;
                    put(s, {prio, key});
                    present[key] = 1;
                    bubble_up(s, 0);
                end
            end else if (kind == KIND_REMOVE) begin
                if (!present[key] || n_held == 0) res.status = ST_ABSENT;
                else begin
                    s = slot_of[key];
                    if (s >= n_held) s = 0;
                    put(s, {TOP_PRIO, key});
                    bubble_up(s, 1);
                    present[key] = 0;
                    if (n_held == 1) n_held = 0;
                    else begin
                        put(0, slots[n_held - 1]);
                        n_held--;
                        bubble_down(0);
                    end
                end
            end else if (kind == KIND_QUERY) begin
                if (n_held == 0) res.status = ST_EMPTY;
                else begin
                    mn = slots[n_held / 2];
                    for (int i = n_held / 2 + 1; i < n_held; i++)
                        if (slots[i] < mn) mn = slots[i];
                end
            end
            res.count = n_held[8:0];
            if (n_held != 0) begin
                res.top_key = slots[0][7:0];
                res.top_prio = slots[0][39:8];
            end
            res.min_key = mn[7:0];
            res.min_prio = mn[39:8];
            pending.push_back(res);
        endfunction

        function void check_result(logic [95:0] beat);
            heap_result_t got;
            heap_result_t exp;
            got = beat[91:0];
            n_checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, beat);
                n_errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status exp %0d got %0d", $realtime, exp.status, got.status);
                n_errors++;
            end
            if (got.count !== exp.count) begin
                $display("%0t: count exp %0d got %0d", $realtime, exp.count, got.count);
                n_errors++;
            end
            if (got.top_key !== exp.top_key) begin
                $display("%0t: top_key exp %h got %h", $realtime, exp.top_key, got.top_key);
                n_errors++;
            end
            if (got.top_prio !== exp.top_prio) begin
                $display("%0t: top_priority exp %h got %h", $realtime,
                         exp.top_prio, got.top_prio);
                n_errors++;
            end
            if (got.min_key !== exp.min_key) begin
                $display("%0t: min_key exp %h got %h", $realtime, exp.min_key, got.min_key);
                n_errors++;
            end
            if (got.min_prio !== exp.min_prio) begin
                $display("%0t: min_priority exp %h got %h", $realtime,
                         exp.min_prio, got.min_prio);
                n_errors++;
            end
            if (beat[95:92] !== '0) begin
                $display("%0t: padding exp 0 got %h", $realtime, beat[95:92]);
                n_errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;

    heap_scoreboard sb;
    int  cycle = 0;
    bit  long_hold;
    bit  hold_done;
    int  burst_left;

    indexed_max_heap_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYC) begin
            $display("timeout after %0d cycles", cycle);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: own stall pattern, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (!rst_n || long_hold) m_axis_tready <= 1'b0;
        else if (cycle[9:8] == 2'b01) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        int hold;
        long_hold = 0;
        hold_done = 0;
        wait (cycle == 3000);
        long_hold = 1;
        for (hold = 0; hold < 300; hold++)
            @(posedge clk);
        long_hold = 0;
        hold_done = 1;
    end

    // Offer one beat; bursts with random gaps keep valid high across items.
    task automatic send_op(logic [1:0] kind, logic [7:0] key, logic [31:0] prio);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {prio, key};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_item(kind, key, prio);
        burst_left--;
        if (burst_left == 0)
            s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        if (burst_left != 0)
            s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_prio();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return TOP_PRIO;
            2: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [7:0] k;
        logic [1:0] kd;
        int r;
        sb = new();
        burst_left = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_INSERT;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-heap cases, extremes, duplicates, ties at the top.
        send_op(KIND_QUERY,  8'h00, 32'h0);
        send_op(KIND_REMOVE, 8'h05, 32'h0);
        send_op(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 8'h00, 32'h0);
        send_op(KIND_REMOVE, 8'h00, 32'h0);
        send_op(KIND_INSERT, 8'hFF, TOP_PRIO);
        send_op(KIND_INSERT, 8'h01, TOP_PRIO);
        send_op(KIND_INSERT, 8'h00, 32'h0);
        send_op(KIND_INSERT, 8'h80, 32'h8000_0000);
        send_op(KIND_INSERT, 8'h01, 32'h5);
        send_op(KIND_QUERY,  8'h00, 32'h0);
        send_op(KIND_REMOVE, 8'h01, 32'h0);
        send_op(KIND_REMOVE, 8'h01, 32'h0);
        send_op(KIND_QUERY,  8'hAA, 32'h5555_5555);
        drain();

        // Fill to capacity, insert into the full heap, then empty it again.
        for (int i = 0; i < 256; i++)
            if (!sb.present[i]) send_op(KIND_INSERT, i[7:0], rand_prio());
        send_op(KIND_INSERT, 8'h33, 32'h1234_5678);
        send_op(KIND_QUERY, 8'h00, 32'h0);
        for (int i = 0; i < 256; i++)
            send_op(KIND_REMOVE, 8'(255 - i), 32'h0);
        send_op(KIND_QUERY, 8'h00, 32'h0);
        drain();

        // Random: mostly inserts and removes of held keys, some noise.
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            k = 8'($urandom_range(0, 255));
            if (r < 45) kd = KIND_INSERT;
            else if (r < 85) begin
                kd = KIND_REMOVE;
                if ($urandom_range(0, 4) != 0 && sb.n_held != 0)
                    k = sb.slots[$urandom_range(0, sb.n_held - 1)][7:0];
            end else if (r < 97) kd = KIND_QUERY;
            else kd = KIND_UNUSED;
            send_op(kd, k, rand_prio());
            if (n == N_RANDOM / 2) drain();
        end
        drain();
        wait (hold_done);
        repeat (100) @(posedge clk);

        $display("ops: %0d insert, %0d remove, %0d query, %0d unused; %0d results checked",
                 sb.n_ops[0], sb.n_ops[1], sb.n_ops[2], sb.n_ops[3], sb.n_checked);
        $display("covered empty, heap at capacity, duplicate, absent and top-priority ties");
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* files.f */
+incdir+sv
sv/imh_pkg.sv
sv/imh_ram.sv
sv/imh_cmp.sv
sv/indexed_max_heap_top.sv
sv/imh_checker.sv
verif/indexed_max_heap_top_tb.sv
